// ----- rtl/core/gtr2x_pkg.sv -----
// ----------------------------------------------------------------------------
// gtr2x_pkg
// Shared types, constants and helpers for the 2x glyph text renderer.
// ----------------------------------------------------------------------------
package gtr2x_pkg;

   // default sizes of the font stores
   localparam int DEF_MAX_GLYPH_W = 16;
   localparam int DEF_MAX_GLYPH_H = 16;
   localparam int DEF_GLYPH_COUNT = 95;

   // fixed field widths
   localparam int ROW_W     = 16;
   localparam int MASK_W    = 32;
   localparam int COORD_W   = 16;
   localparam int MET_W     = 24;
   localparam int CSR_W     = 5;
   localparam int CSR_IDX_W = 2;

   // printable code range
   localparam logic [7:0] FIRST_PRINTABLE = 8'h20;
   localparam logic [7:0] LAST_PRINTABLE  = 8'h7E;

   // request modes
   localparam logic [1:0] MODE_RENDER    = 2'd0;
   localparam logic [1:0] MODE_WRITE_ROW = 2'd1;
   localparam logic [1:0] MODE_WRITE_MET = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GLYPH_HEIGHT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GLYPH_WIDTH  = 2'd1;

   typedef struct packed {
      logic [1:0]          mode;
      logic [7:0]          char_code;
      logic                first_char;
      logic signed [15:0]  start_x;
      logic signed [15:0]  start_y;
      logic [6:0]          glyph_index;
      logic [3:0]          row_index;
      logic [15:0]         row_bits;
      logic [7:0]          advance;
      logic signed [7:0]   offset_x;
      logic signed [7:0]   offset_y;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0]  line_x;
      logic signed [15:0]  line_y;
      logic [31:0]         line_mask;
      logic signed [15:0]  cursor_after;
      logic                last_line;
   } rsp_payload_type;

   // each of the leftmost w source pixels fills two adjacent mask bits
   function automatic logic [MASK_W-1:0] double_bits(input logic [ROW_W-1:0] row,
                                                     input logic [4:0] w);
      logic [MASK_W-1:0] m;
      m = '0;
      for (int i = 0; i < ROW_W; i++) begin
         if ((5'(i) < w) && row[ROW_W-1-i]) begin
            m[MASK_W-1-2*i] = 1'b1;
            m[MASK_W-2-2*i] = 1'b1;
         end
      end
      return m;
   endfunction

endpackage

// ----- rtl/core/gtr2x_if.sv -----
// ----------------------------------------------------------------------------
// gtr2x_req_if / gtr2x_rsp_if
// Valid/ready channels for request words and rendered line words.
// ----------------------------------------------------------------------------
interface gtr2x_req_if;
   import gtr2x_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface gtr2x_rsp_if;
   import gtr2x_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/glyph_text_render_2x.sv -----
// ----------------------------------------------------------------------------
// glyph_text_render_2x
// Renders characters from a stored 1-bit font as 2x scaled line masks.
// Load words write the row or metric RAM directly. A render word does one
// metric read, then one glyph row read per row from the row RAM and two line
// words per row through the output register; ready only while idle.
// Synchronous active-high reset clears cursor and baseline and sets the height
// and width registers to 8; font RAM contents are undefined until written.
// ----------------------------------------------------------------------------
module glyph_text_render_2x #(
   parameter int MAX_GLYPH_W = gtr2x_pkg::DEF_MAX_GLYPH_W,
   parameter int MAX_GLYPH_H = gtr2x_pkg::DEF_MAX_GLYPH_H,
   parameter int GLYPH_COUNT = gtr2x_pkg::DEF_GLYPH_COUNT
) (
   input  logic                              clock,
   input  logic                              reset,
   gtr2x_req_if.sink                         req_chan,
   gtr2x_rsp_if.source                       rsp_chan,
   input  logic                              csr_we,
   input  logic [gtr2x_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gtr2x_pkg::CSR_W-1:0]       csr_wdata
);
   import gtr2x_pkg::*;

   localparam int ROW_DEPTH = GLYPH_COUNT * MAX_GLYPH_H;
   localparam int ROW_AW    = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
   localparam int MET_AW    = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
   localparam int RW        = $clog2(MAX_GLYPH_H + 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_META  = 4'b0010,
      ST_EMIT0 = 4'b0100,
      ST_EMIT1 = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [CSR_W-1:0]  height_ff, height_in;
   logic [CSR_W-1:0]  width_ff, width_in;
   logic [COORD_W-1:0] cursor_ff, cursor_in;
   logic [COORD_W-1:0] base_ff, base_in;
   logic [COORD_W-1:0] line_x_ff, line_x_in;
   logic [COORD_W-1:0] line_y_ff, line_y_in;
   logic [COORD_W-1:0] after_ff, after_in;
   logic [MASK_W-1:0]  mask_ff, mask_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [ROW_AW-1:0]  raddr_ff, raddr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_ff, rsp_in;

   req_payload_type   req;
   logic              req_fire;
   logic [7:0]        glyph_num;
   logic              printable;
   logic              slot_free;
   logic [RW-1:0]     h_eff;
   logic [4:0]        w_eff;
   logic              last_row;
   logic [MASK_W-1:0] row_mask;

   logic              row_we, row_re;
   logic [ROW_AW-1:0] row_waddr, row_raddr;
   logic [ROW_W-1:0]  row_rdata;
   logic              met_we, met_re;
   logic [MET_AW-1:0] met_waddr, met_raddr;
   logic [MET_W-1:0]  met_wdata, met_rdata;
   logic [COORD_W-1:0] off_x_ext, off_y_ext;

   assign req = req_chan.payload;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire = req_chan.valid && req_chan.ready;

   // printable code that maps to a stored glyph slot
   assign glyph_num = req.char_code - FIRST_PRINTABLE;
   assign printable = (req.char_code >= FIRST_PRINTABLE) &&
                      (req.char_code <= LAST_PRINTABLE) &&
                      (int'(glyph_num) < GLYPH_COUNT);

   // effective glyph size after saturation
   assign h_eff = (int'(height_ff) > MAX_GLYPH_H) ? RW'(MAX_GLYPH_H) : RW'(height_ff);
   always_comb begin
      w_eff = width_ff;
      if (int'(w_eff) > MAX_GLYPH_W) begin
         w_eff = 5'(MAX_GLYPH_W);
      end
      if (int'(w_eff) > ROW_W) begin
         w_eff = 5'(ROW_W);
      end
   end

   assign last_row  = (RW'(row_ff + RW'(1)) == h_eff);
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign row_mask  = double_bits(row_rdata, w_eff);

   // font store writes
   assign row_we    = req_fire && (req.mode == MODE_WRITE_ROW) &&
                      (int'(req.glyph_index) < GLYPH_COUNT) &&
                      (int'(req.row_index) < MAX_GLYPH_H);
   assign row_waddr = ROW_AW'(ROW_AW'(req.glyph_index) * ROW_AW'(MAX_GLYPH_H)) +
                      ROW_AW'(req.row_index);
   assign met_we    = req_fire && (req.mode == MODE_WRITE_MET) &&
                      (int'(req.glyph_index) < GLYPH_COUNT);
   assign met_waddr = MET_AW'(req.glyph_index);
   assign met_wdata = {req.advance, req.offset_x, req.offset_y};

   // font store reads
   assign met_re    = req_fire && (req.mode == MODE_RENDER) && printable;
   assign met_raddr = MET_AW'(glyph_num);
   assign row_re    = ((state_ff == ST_META) && (h_eff != '0)) ||
                      ((state_ff == ST_EMIT0) && slot_free && !last_row);
   assign row_raddr = (state_ff == ST_META) ? raddr_ff : ROW_AW'(raddr_ff + ROW_AW'(1));

   gtr2x_ram #(.WIDTH(ROW_W), .DEPTH(ROW_DEPTH)) u_row_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (row_waddr),
      .wr_data (req.row_bits),
      .rd_en   (row_re),
      .rd_addr (row_raddr),
      .rd_data (row_rdata)
   );

   gtr2x_ram #(.WIDTH(MET_W), .DEPTH(GLYPH_COUNT)) u_met_ram (
      .clock   (clock),
      .wr_en   (met_we),
      .wr_addr (met_waddr),
      .wr_data (met_wdata),
      .rd_en   (met_re),
      .rd_addr (met_raddr),
      .rd_data (met_rdata)
   );

   assign off_x_ext = {{8{met_rdata[15]}}, met_rdata[15:8]};
   assign off_y_ext = {{8{met_rdata[7]}}, met_rdata[7:0]};

   // sequencer
   always_comb begin
      state_in     = state_ff;
      height_in    = height_ff;
      width_in     = width_ff;
      cursor_in    = cursor_ff;
      base_in      = base_ff;
      line_x_in    = line_x_ff;
      line_y_in    = line_y_ff;
      after_in     = after_ff;
      mask_in      = mask_ff;
      row_in       = row_ff;
      raddr_in     = raddr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_in       = rsp_ff;

      // register writes
      if (csr_we) begin
         case (csr_index)
            CSR_GLYPH_HEIGHT: height_in = csr_wdata;
            CSR_GLYPH_WIDTH:  width_in  = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req.mode == MODE_RENDER)) begin
               if (req.first_char) begin
                  cursor_in = req.start_x;
                  base_in   = req.start_y;
               end
               if (printable) begin
                  raddr_in = ROW_AW'(ROW_AW'(glyph_num) * ROW_AW'(MAX_GLYPH_H));
                  state_in = ST_META;
               end
            end
         end
         ST_META: begin
            line_x_in = (cursor_ff + off_x_ext);
            line_y_in = (base_ff + off_y_ext);
            after_in  = cursor_ff + {7'd0, met_rdata[23:16], 1'b0};
            row_in    = '0;
            if (h_eff == '0) begin
               cursor_in = cursor_ff + {7'd0, met_rdata[23:16], 1'b0};
               state_in  = ST_IDLE;
            end else begin
               state_in = ST_EMIT0;
            end
         end
         ST_EMIT0: begin
            if (slot_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.line_x        = line_x_ff;
               rsp_in.line_y        = line_y_ff;
               rsp_in.line_mask     = row_mask;
               rsp_in.cursor_after  = after_ff;
               rsp_in.last_line     = 1'b0;
               mask_in              = row_mask;
               line_y_in            = line_y_ff + COORD_W'(1);
               if (!last_row) begin
                  raddr_in = ROW_AW'(raddr_ff + ROW_AW'(1));
               end
               state_in = ST_EMIT1;
            end
         end
         ST_EMIT1: begin
            if (slot_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.line_x        = line_x_ff;
               rsp_in.line_y        = line_y_ff;
               rsp_in.line_mask     = mask_ff;
               rsp_in.cursor_after  = after_ff;
               rsp_in.last_line     = last_row;
               line_y_in            = line_y_ff + COORD_W'(1);
               if (last_row) begin
                  cursor_in = after_ff;
                  state_in  = ST_IDLE;
               end else begin
                  row_in   = RW'(row_ff + RW'(1));
                  state_in = ST_EMIT0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         height_ff    <= CSR_W'(8);
         width_ff     <= CSR_W'(8);
         cursor_ff    <= '0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         height_ff    <= height_in;
         width_ff     <= width_in;
         cursor_ff    <= cursor_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      line_x_ff <= line_x_in;
      line_y_ff <= line_y_in;
      after_ff  <= after_in;
      mask_ff   <= mask_in;
      row_ff    <= row_in;
      raddr_ff  <= raddr_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

endmodule

// ----- rtl/core/gtr2x_ram.sv -----
// ----------------------------------------------------------------------------
// gtr2x_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gtr2x_ram #(
   parameter  int WIDTH = 16,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
